### hdl/multitap_text_entry_assert.svh
// Assertion macros used by the checker file.
`ifndef MULTITAP_TEXT_ENTRY_ASSERT_SVH
`define MULTITAP_TEXT_ENTRY_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define MTE_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("multitap_text_entry assertion failed");

// Next-cycle implication, disabled while in reset.
`define MTE_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("multitap_text_entry assertion failed");

`endif

### hdl/mte_pkg.sv
package mte_pkg;

  // Item kinds on in_tuser
  localparam logic [1:0] KIND_TOUCH = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Result status on out_tuser
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_EDIT    = 2'd1;
  localparam logic [1:0] ST_SUBMIT  = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_CYCLE_PERIOD  = 3'd0;
  localparam logic [2:0] REG_KEY_WIDTH     = 3'd1;
  localparam logic [2:0] REG_KEY_HEIGHT    = 3'd2;
  localparam logic [2:0] REG_KEYPAD_TOP    = 3'd3;
  localparam logic [2:0] REG_KEYPAD_BOTTOM = 3'd4;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd5;

  // Register reset values
  localparam logic [15:0] RST_CYCLE_PERIOD  = 16'd80;
  localparam logic [11:0] RST_KEY_WIDTH     = 12'd80;
  localparam logic [11:0] RST_KEY_HEIGHT    = 12'd40;
  localparam logic [11:0] RST_KEYPAD_TOP    = 12'd160;
  localparam logic [11:0] RST_KEYPAD_BOTTOM = 12'd320;
  localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd240;

  // Keypad geometry; also the quotient limits of the cell search
  localparam logic [2:0] KEY_ROWS = 3'd4;
  localparam logic [2:0] KEY_COLS = 3'd3;

  typedef enum logic [1:0] {
    KEY_LETTER,
    KEY_DEL,
    KEY_SUB
  } key_class_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;       // capture input beat, start row search
    logic start_col;  // save row, start column search
    logic step;       // one subtract step of the cell search
    logic commit;     // update state, load result register
  } mte_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_touch;   // beat on the input is a touch
    logic div_done;   // cell search finished
    logic out_free;   // result register can take a new result
  } mte_sts_t;

  function automatic key_class_t key_class(input logic [1:0] row, input logic [1:0] col);
    key_class_t k;
    k = KEY_LETTER;
    if (row == 2'd3 && col == 2'd0) k = KEY_DEL;
    if (row == 2'd3 && col == 2'd2) k = KEY_SUB;
    return k;
  endfunction

  function automatic logic [2:0] seq_len(input logic [1:0] row, input logic [1:0] col);
    logic [2:0] n;
    unique case ({row, col})
      4'b10_00, 4'b10_10: n = 3'd5;
      4'b11_01:           n = 3'd2;
      4'b11_00, 4'b11_10: n = 3'd0;
      default:            n = 3'd4;
    endcase
    return n;
  endfunction

  // Letter sequence of a key, first letter in the low byte
  function automatic logic [7:0] seq_char(input logic [1:0] row, input logic [1:0] col,
                                          input logic [2:0] idx);
    logic [63:0] s;
    unique case ({row, col})
      4'b00_00: s = {32'h0, "1-,."};
      4'b00_01: s = {32'h0, "2cba"};
      4'b00_10: s = {32'h0, "3fed"};
      4'b01_00: s = {32'h0, "4ihg"};
      4'b01_01: s = {32'h0, "5lkj"};
      4'b01_10: s = {32'h0, "6onm"};
      4'b10_00: s = {24'h0, "7srqp"};
      4'b10_01: s = {32'h0, "8vut"};
      4'b10_10: s = {24'h0, "9zyxw"};
      4'b11_01: s = {48'h0, "0 "};
      default:  s = 64'h0;
    endcase
    return s[{idx, 3'b000} +: 8];
  endfunction

endpackage

### hdl/mte_ctrl.sv
module mte_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  mte_pkg::mte_sts_t sts,
  output mte_pkg::mte_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROW,
    S_COL,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  // Sequencing: accept, row search, column search (touches only), commit
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_ready_r) begin
          cmd.load  = 1'b1;
          state_nxt = sts.in_touch ? S_ROW : S_DONE;
        end
      end
      S_ROW: begin
        if (sts.div_done) begin
          cmd.start_col = 1'b1;
          state_nxt     = S_COL;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_COL: begin
        if (sts.div_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_tready = in_ready_r;

endmodule

### hdl/mte_datapath.sv
module mte_datapath #(
  parameter int TEXT_CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [55:0]       in_tdata,
  input  logic [1:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,
  output logic [1:0]        out_tuser,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  mte_pkg::mte_cmd_t cmd,
  output mte_pkg::mte_sts_t sts
);

  localparam int LW = $clog2(TEXT_CAPACITY);
  localparam int EW = LW + 6;
  localparam logic [LW:0] CAP = (LW + 1)'(TEXT_CAPACITY);

  // Configuration registers
  logic [15:0] period_r;
  logic [11:0] kw_r, kh_r, top_r, bot_r, scr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= mte_pkg::RST_CYCLE_PERIOD;
      kw_r     <= mte_pkg::RST_KEY_WIDTH;
      kh_r     <= mte_pkg::RST_KEY_HEIGHT;
      top_r    <= mte_pkg::RST_KEYPAD_TOP;
      bot_r    <= mte_pkg::RST_KEYPAD_BOTTOM;
      scr_r    <= mte_pkg::RST_SCREEN_WIDTH;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mte_pkg::REG_CYCLE_PERIOD:  period_r <= cfg_data;
        mte_pkg::REG_KEY_WIDTH:     kw_r     <= cfg_data[11:0];
        mte_pkg::REG_KEY_HEIGHT:    kh_r     <= cfg_data[11:0];
        mte_pkg::REG_KEYPAD_TOP:    top_r    <= cfg_data[11:0];
        mte_pkg::REG_KEYPAD_BOTTOM: bot_r    <= cfg_data[11:0];
        mte_pkg::REG_SCREEN_WIDTH:  scr_r    <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Captured input item
  logic [1:0]  kind_r;
  logic [11:0] x_r, y_r;
  logic [31:0] now_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_tuser;
      x_r    <= in_tdata[11:0];
      y_r    <= in_tdata[23:12];
      now_r  <= in_tdata[55:24];
    end
  end

  // Cell search: repeated subtraction, quotient capped at the key count
  logic [11:0] rem_r;
  logic [2:0]  q_r, row_r;
  logic        col_phase_r;
  logic [11:0] kw_eff, kh_eff, div_k;
  logic [2:0]  div_lim;

  assign kw_eff  = (kw_r == 12'd0) ? 12'd1 : kw_r;
  assign kh_eff  = (kh_r == 12'd0) ? 12'd1 : kh_r;
  assign div_k   = col_phase_r ? kw_eff : kh_eff;
  assign div_lim = col_phase_r ? mte_pkg::KEY_COLS : mte_pkg::KEY_ROWS;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r       <= in_tdata[23:12] - top_r;
      q_r         <= 3'd0;
      col_phase_r <= 1'b0;
    end else if (cmd.start_col) begin
      row_r       <= q_r;
      rem_r       <= x_r;
      q_r         <= 3'd0;
      col_phase_r <= 1'b1;
    end else if (cmd.step) begin
      rem_r <= rem_r - div_k;
      q_r   <= q_r + 3'd1;
    end
  end

  // Text and live-key state
  logic [LW-1:0] len_r, len_c;
  logic          live_r, live_c;
  logic [1:0]    lrow_r, lrow_c, lcol_r, lcol_c;
  logic [2:0]    idx_r, idx_c;
  logic [31:0]   last_r, last_c;

  // Commit decision
  logic                 oob, same, full, expired;
  logic [1:0]           row2, col2;
  mte_pkg::key_class_t  kcls;
  logic [2:0]           n_seq, idx_wrap;
  logic [3:0]           idx_inc;
  logic [LW-1:0]        len_dec;
  logic [31:0]          elapsed;
  logic [1:0]           st_c;
  logic                 wv_c;
  logic [LW-1:0]        wp_c;
  logic [7:0]           wc_c;

  assign row2     = row_r[1:0];
  assign col2     = q_r[1:0];
  assign oob      = (y_r < top_r) || (y_r >= bot_r) || (x_r >= scr_r) ||
                    (row_r >= mte_pkg::KEY_ROWS) || (q_r >= mte_pkg::KEY_COLS);
  assign kcls     = mte_pkg::key_class(row2, col2);
  assign same     = live_r && (lrow_r == row2) && (lcol_r == col2);
  assign n_seq    = mte_pkg::seq_len(row2, col2);
  assign idx_inc  = {1'b0, idx_r} + 4'd1;
  assign idx_wrap = (idx_inc >= {1'b0, n_seq}) ? 3'(idx_inc - {1'b0, n_seq})
                                                : idx_inc[2:0];
  assign len_dec  = len_r - LW'(1);
  assign full     = ({1'b0, len_r} + (LW + 1)'(1)) >= CAP;
  assign elapsed  = now_r - last_r;
  assign expired  = elapsed >= {16'd0, period_r};

  always_comb begin
    st_c   = mte_pkg::ST_NONE;
    wv_c   = 1'b0;
    wp_c   = '0;
    wc_c   = 8'd0;
    len_c  = len_r;
    live_c = live_r;
    lrow_c = lrow_r;
    lcol_c = lcol_r;
    idx_c  = idx_r;
    last_c = last_r;
    unique case (kind_r)
      mte_pkg::KIND_TOUCH: begin
        if (!oob) begin
          unique case (kcls)
            mte_pkg::KEY_DEL: begin
              live_c = 1'b0;
              st_c   = mte_pkg::ST_EDIT;
              if (len_r != '0) begin
                len_c = len_dec;
                wv_c  = 1'b1;
                wp_c  = len_dec;
              end
            end
            mte_pkg::KEY_SUB: begin
              live_c = 1'b0;
              st_c   = mte_pkg::ST_SUBMIT;
            end
            default: begin
              if (same) begin
                // cycle the live key, rewrite last character
                idx_c  = idx_wrap;
                last_c = now_r;
                st_c   = mte_pkg::ST_EDIT;
                if (len_r != '0) begin
                  wv_c = 1'b1;
                  wp_c = len_dec;
                  wc_c = mte_pkg::seq_char(row2, col2, idx_wrap);
                end
              end else begin
                live_c = 1'b0;
                if (!full) begin
                  // append first letter of the new key
                  idx_c  = 3'd0;
                  len_c  = LW'({1'b0, len_r} + (LW + 1)'(1));
                  live_c = 1'b1;
                  lrow_c = row2;
                  lcol_c = col2;
                  last_c = now_r;
                  st_c   = mte_pkg::ST_EDIT;
                  wv_c   = 1'b1;
                  wp_c   = len_r;
                  wc_c   = mte_pkg::seq_char(row2, col2, 3'd0);
                end
              end
            end
          endcase
        end
      end
      mte_pkg::KIND_TICK: begin
        if (live_r && expired) begin
          live_c = 1'b0;
          st_c   = mte_pkg::ST_TIMEOUT;
        end
      end
      mte_pkg::KIND_CLEAR: begin
        len_c  = '0;
        live_c = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      live_r <= 1'b0;
      lrow_r <= 2'd0;
      lcol_r <= 2'd0;
      idx_r  <= 3'd0;
      last_r <= 32'd0;
    end else if (cmd.commit) begin
      len_r  <= len_c;
      live_r <= live_c;
      lrow_r <= lrow_c;
      lcol_r <= lcol_c;
      idx_r  <= idx_c;
      last_r <= last_c;
    end
  end

  // Result register
  logic          out_valid_r;
  logic [1:0]    st_r;
  logic [25:0]   res_r;
  logic [EW-1:0] len_w, wp_w;

  assign len_w = EW'(len_c);
  assign wp_w  = EW'(wp_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      st_r  <= st_c;
      res_r <= {live_c ? lcol_c : 2'd0,
                live_c ? lrow_c : 2'd0,
                live_c,
                wc_c,
                wp_w[5:0],
                wv_c,
                len_w[5:0]};
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {6'd0, res_r};
  assign out_tuser    = st_r;
  assign sts.in_touch = (in_tuser == mte_pkg::KIND_TOUCH);
  assign sts.div_done = (rem_r < div_k) || (q_r == div_lim);
  assign sts.out_free = !out_valid_r || out_tready;

endmodule

### hdl/multitap_text_entry.sv
// Multi-tap keypad text entry over a 4x3 phone keypad.
// Input channel in_*: one beat per event. in_tuser = kind (touch, time check,
// clear); in_tdata = touch_x, touch_y, now. Every beat gives exactly one
// result beat on out_*: out_tuser = status, out_tdata = text length, the
// position/character written (if any) and the live key.
// Config channel cfg_*: register index and data, ready whenever out of reset;
// write only while no item is in flight.
// A time check, clear or unused kind goes from accept straight to the
// commit state. A touch runs a cell search by repeated subtraction of the key
// height (up to 4 steps) and then of the key width (up to 3 steps), one
// subtract per cycle plus a check that ends each search, then a commit.
// One item is in flight at a time; in_tready is low from accept until the
// result is loaded. A result waits in the output register while out_tready
// is low; the next item is accepted and searched meanwhile, and holds at
// commit until the register frees.
// Reset (rst_n low, synchronous) empties the text, drops the live key,
// clears the output register and restores the register defaults; in_tready
// is registered and rises in the cycle after reset is released.
module multitap_text_entry #(
  parameter int TEXT_CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // touch_x[11:0], touch_y[23:12], now[55:24]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // text_length[5:0], write_valid[6], write_pos[12:7], write_char[20:13],
  // live_valid[21], live_row[23:22], live_col[25:24], zero[31:26]
  output logic [31:0] out_tdata,
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  mte_pkg::mte_cmd_t cmd;
  mte_pkg::mte_sts_t sts;

  assign cfg_ready = rst_n;

  mte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mte_datapath #(
    .TEXT_CAPACITY (TEXT_CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

### hdl/mte_checker.sv
`include "multitap_text_entry_assert.svh"

module mte_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // stalled result beat holds
  `MTE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // one item in flight: no accept on the cycle after an accept
  `MTE_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // no write reported: position and character are zero
  `MTE_ASSERT_SAME(a_no_write_zero, clk, rst_n, out_tvalid && !out_tdata[6], out_tdata[20:7] == 14'd0)

  // no live key: row and column are zero
  `MTE_ASSERT_SAME(a_no_live_zero, clk, rst_n, out_tvalid && !out_tdata[21], out_tdata[25:22] == 4'd0)

  // submit and timeout both settle the live key
  `MTE_ASSERT_SAME(a_settle_drops_live, clk, rst_n, out_tvalid && (out_tuser == mte_pkg::ST_SUBMIT || out_tuser == mte_pkg::ST_TIMEOUT), !out_tdata[21])

endmodule

bind multitap_text_entry mte_checker u_mte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### bench/multitap_text_entry_tb.sv
`timescale 1ns / 1ps

module multitap_text_entry_tb;

  localparam int TEXT_CAP = 64;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 30;
  localparam int MAX_PRINTED = 50;

  // Kind that the block must ignore; not named in the package
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Register indexes past the end of the map; writes must be ignored
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // Key positions with a function of their own
  localparam int DEL_ROW = 3;
  localparam int DEL_COL = 0;
  localparam int SUB_ROW = 3;
  localparam int SUB_COL = 2;
  localparam int SPACE_ROW = 3;
  localparam int SPACE_COL = 1;

  // Result beat as packed on out_tdata, last field in the low bits
  typedef struct packed {
    logic [5:0] pad;
    logic [1:0] live_col;
    logic [1:0] live_row;
    logic       live_valid;
    logic [7:0] write_char;
    logic [5:0] write_pos;
    logic       write_valid;
    logic [5:0] text_length;
  } text_beat_t;

  typedef struct packed {
    logic [1:0] status;
    text_beat_t beat;
  } keypad_result_t;

  typedef struct {
    logic [1:0]  kind;
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] now;
  } tap_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;   // touch_x[11:0], touch_y[23:12], now[55:24]
  logic [1:0]  in_tuser = '0;   // kind[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // see text_beat_t, low field last
  logic [1:0]  out_tuser;       // status[1:0]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  multitap_text_entry #(
    .TEXT_CAPACITY(TEXT_CAP)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // Stimulus and expectation stores
  tap_item_t      tap_q[$];
  keypad_result_t keypad_results_q[$];

  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // Shadow copy of the registers
  logic [15:0] cyc_period;
  logic [11:0] key_w, key_h, pad_top, pad_bottom, scr_w;

  // Shadow copy of the entry state
  int unsigned text_len;
  bit          live_on;
  logic [1:0]  live_r, live_c;
  int unsigned cyc_idx;
  logic [31:0] last_tap;

  // Stimulus-side bookkeeping
  logic [31:0] sim_ticks = '0;
  int          last_key_r = 0;
  int          last_key_c = 0;

  tap_item_t      drv_item;
  keypad_result_t want_res;
  text_beat_t     got_beat;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MAX_PRINTED)
      $display("%0t mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Letter sequence of a key; empty for delete and submit
  function automatic string key_letters(input int r, input int c);
    case (r * 3 + c)
      0:       return ".,-1";
      1:       return "abc2";
      2:       return "def3";
      3:       return "ghi4";
      4:       return "jkl5";
      5:       return "mno6";
      6:       return "pqrs7";
      7:       return "tuv8";
      8:       return "wxyz9";
      10:      return " 0";
      default: return "";
    endcase
  endfunction

  task automatic push_result(input logic [1:0] st, input bit wv, input int unsigned wp,
                             input logic [7:0] wc);
    keypad_result_t res;
    res = '0;
    res.status = st;
    res.beat.text_length = text_len[5:0];
    res.beat.write_valid = wv;
    if (wv) begin
      res.beat.write_pos = wp[5:0];
      res.beat.write_char = wc;
    end
    res.beat.live_valid = live_on;
    if (live_on) begin
      res.beat.live_row = live_r;
      res.beat.live_col = live_c;
    end
    keypad_results_q.push_back(res);
  endtask

  // Expected result of one accepted beat; updates the shadow state
  task automatic predict_keypad_result(input logic [1:0] kind, input logic [11:0] x,
                                       input logic [11:0] y, input logic [31:0] now);
    int    kw, kh, r, c;
    string seq;
    logic [31:0] elapsed;
    kw = (key_w == 0) ? 1 : int'(key_w);
    kh = (key_h == 0) ? 1 : int'(key_h);
    case (kind)
      mte_pkg::KIND_TOUCH: begin
        if (y < pad_top || y >= pad_bottom || x >= scr_w) begin
          push_result(mte_pkg::ST_NONE, 1'b0, 0, 8'h0);
          return;
        end
        r = (int'(y) - int'(pad_top)) / kh;
        c = int'(x) / kw;
        if (r >= int'(mte_pkg::KEY_ROWS) || c >= int'(mte_pkg::KEY_COLS)) begin
          push_result(mte_pkg::ST_NONE, 1'b0, 0, 8'h0);
        end else if (r == DEL_ROW && c == DEL_COL) begin
          live_on = 1'b0;
          if (text_len != 0) begin
            text_len--;
            push_result(mte_pkg::ST_EDIT, 1'b1, text_len, 8'h0);
          end else begin
            push_result(mte_pkg::ST_EDIT, 1'b0, 0, 8'h0);
          end
        end else if (r == SUB_ROW && c == SUB_COL) begin
          live_on = 1'b0;
          push_result(mte_pkg::ST_SUBMIT, 1'b0, 0, 8'h0);
        end else begin
          seq = key_letters(r, c);
          if (live_on && live_r == r[1:0] && live_c == c[1:0]) begin
            // same key again: step through its letters
            cyc_idx = (cyc_idx + 1) % seq.len();
            last_tap = now;
            if (text_len != 0)
              push_result(mte_pkg::ST_EDIT, 1'b1, text_len - 1, seq.getc(cyc_idx));
            else
              push_result(mte_pkg::ST_EDIT, 1'b0, 0, 8'h0);
          end else begin
            live_on = 1'b0;
            if (text_len + 1 >= TEXT_CAP) begin
              push_result(mte_pkg::ST_NONE, 1'b0, 0, 8'h0);
            end else begin
              cyc_idx = 0;
              text_len++;
              live_on = 1'b1;
              live_r = r[1:0];
              live_c = c[1:0];
              last_tap = now;
              push_result(mte_pkg::ST_EDIT, 1'b1, text_len - 1, seq.getc(0));
            end
          end
        end
      end
      mte_pkg::KIND_TICK: begin
        elapsed = now - last_tap;
        if (live_on && elapsed >= {16'h0, cyc_period}) begin
          live_on = 1'b0;
          push_result(mte_pkg::ST_TIMEOUT, 1'b0, 0, 8'h0);
        end else begin
          push_result(mte_pkg::ST_NONE, 1'b0, 0, 8'h0);
        end
      end
      mte_pkg::KIND_CLEAR: begin
        text_len = 0;
        live_on = 1'b0;
        push_result(mte_pkg::ST_NONE, 1'b0, 0, 8'h0);
      end
      default: push_result(mte_pkg::ST_NONE, 1'b0, 0, 8'h0);
    endcase
  endtask

  // Driver: offers queued items, predicts each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        predict_keypad_result(in_tuser, in_tdata[11:0], in_tdata[23:12], in_tdata[55:24]);
      if (!in_tvalid || in_tready) begin
        if (tap_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drv_item = tap_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= drv_item.kind;
          in_tdata <= {drv_item.now, drv_item.y, drv_item.x};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready, with random stalls and an optional long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (keypad_results_q.size() == 0) begin
        report_mismatch("unexpected result beat", out_tdata, 32'h0);
      end else begin
        want_res = keypad_results_q.pop_front();
        got_beat = out_tdata;
        if (out_tuser != want_res.status)
          report_mismatch("status", out_tuser, want_res.status);
        if (got_beat.text_length != want_res.beat.text_length)
          report_mismatch("text_length", got_beat.text_length, want_res.beat.text_length);
        if (got_beat.write_valid != want_res.beat.write_valid)
          report_mismatch("write_valid", got_beat.write_valid, want_res.beat.write_valid);
        if (got_beat.write_pos != want_res.beat.write_pos)
          report_mismatch("write_pos", got_beat.write_pos, want_res.beat.write_pos);
        if (got_beat.write_char != want_res.beat.write_char)
          report_mismatch("write_char", got_beat.write_char, want_res.beat.write_char);
        if (got_beat.live_valid != want_res.beat.live_valid)
          report_mismatch("live_valid", got_beat.live_valid, want_res.beat.live_valid);
        if (got_beat.live_row != want_res.beat.live_row)
          report_mismatch("live_row", got_beat.live_row, want_res.beat.live_row);
        if (got_beat.live_col != want_res.beat.live_col)
          report_mismatch("live_col", got_beat.live_col, want_res.beat.live_col);
        if (got_beat.pad != want_res.beat.pad)
          report_mismatch("tdata padding", got_beat.pad, want_res.beat.pad);
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("multitap_text_entry_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_item(input logic [1:0] kind, input int x, input int y,
                           input logic [31:0] now);
    tap_item_t it;
    it.kind = kind;
    it.x = x[11:0];
    it.y = y[11:0];
    it.now = now;
    tap_q.push_back(it);
  endtask

  // Touch somewhere inside key (r, c) of the current geometry
  task automatic tap_key(input int r, input int c);
    int kw, kh, x, y;
    kw = (key_w == 0) ? 1 : int'(key_w);
    kh = (key_h == 0) ? 1 : int'(key_h);
    x = c * kw + $urandom_range(0, kw - 1);
    y = int'(pad_top) + r * kh + $urandom_range(0, kh - 1);
    push_item(mte_pkg::KIND_TOUCH, x, y, sim_ticks);
  endtask

  // Mostly well-formed typing with random content, some noise
  task automatic queue_random_typing(input int count);
    int sel, k;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 15) == 0)
        sim_ticks += $urandom;
      else
        sim_ticks += $urandom_range(0, int'(cyc_period) / 2 + 8);
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        k = $urandom_range(0, 9);
        if (k == 9) begin
          last_key_r = SPACE_ROW;
          last_key_c = SPACE_COL;
        end else begin
          last_key_r = k / 3;
          last_key_c = k % 3;
        end
        tap_key(last_key_r, last_key_c);
      end else if (sel < 65) begin
        tap_key(last_key_r, last_key_c);
      end else if (sel < 73) begin
        tap_key(DEL_ROW, DEL_COL);
      end else if (sel < 76) begin
        tap_key(SUB_ROW, SUB_COL);
      end else if (sel < 90) begin
        push_item(mte_pkg::KIND_TICK, $urandom, $urandom, sim_ticks);
      end else if (sel < 95) begin
        push_item(mte_pkg::KIND_TOUCH, $urandom_range(0, 4095), $urandom_range(0, 4095),
                  sim_ticks);
      end else if (sel < 97) begin
        push_item(KIND_UNUSED, $urandom, $urandom, $urandom);
      end else if (sel < 98) begin
        push_item(mte_pkg::KIND_CLEAR, $urandom, $urandom, sim_ticks);
      end else begin
        // just outside the keypad edges
        push_item(mte_pkg::KIND_TOUCH, int'(scr_w) + $urandom_range(0, 3),
                  int'(pad_top) - $urandom_range(1, 3), sim_ticks);
      end
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      mte_pkg::REG_CYCLE_PERIOD:  cyc_period = val;
      mte_pkg::REG_KEY_WIDTH:     key_w = val[11:0];
      mte_pkg::REG_KEY_HEIGHT:    key_h = val[11:0];
      mte_pkg::REG_KEYPAD_TOP:    pad_top = val[11:0];
      mte_pkg::REG_KEYPAD_BOTTOM: pad_bottom = val[11:0];
      mte_pkg::REG_SCREEN_WIDTH:  scr_w = val[11:0];
      default: ;
    endcase
  endtask

  task automatic load_geometry(input logic [15:0] cp, input logic [15:0] kw,
                               input logic [15:0] kh, input logic [15:0] top,
                               input logic [15:0] bottom, input logic [15:0] sw);
    write_reg(mte_pkg::REG_CYCLE_PERIOD, cp);
    write_reg(mte_pkg::REG_KEY_WIDTH, kw);
    write_reg(mte_pkg::REG_KEY_HEIGHT, kh);
    write_reg(mte_pkg::REG_KEYPAD_TOP, top);
    write_reg(mte_pkg::REG_KEYPAD_BOTTOM, bottom);
    write_reg(mte_pkg::REG_SCREEN_WIDTH, sw);
    @(negedge clk);
  endtask

  // Sender pause: wait until every item went out and every result came back
  task automatic wait_drained();
    while (tap_q.size() != 0 || in_tvalid || keypad_results_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    // reset values of the registers and the entry state
    cyc_period = mte_pkg::RST_CYCLE_PERIOD;
    key_w = mte_pkg::RST_KEY_WIDTH;
    key_h = mte_pkg::RST_KEY_HEIGHT;
    pad_top = mte_pkg::RST_KEYPAD_TOP;
    pad_bottom = mte_pkg::RST_KEYPAD_BOTTOM;
    scr_w = mte_pkg::RST_SCREEN_WIDTH;
    text_len = 0;
    live_on = 1'b0;
    live_r = '0;
    live_c = '0;
    cyc_idx = 0;
    last_tap = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    set_idling(33, 66);

    // Directed part at reset geometry: 80x40 keys, rows 160..319, width 240
    push_item(mte_pkg::KIND_TOUCH, 0, 160, 10);              // first key corner: '.'
    push_item(mte_pkg::KIND_TOUCH, 79, 199, 20);             // opposite corner, cycles
    push_item(mte_pkg::KIND_TOUCH, 40, 180, 30);
    push_item(mte_pkg::KIND_TOUCH, 40, 180, 50);
    push_item(mte_pkg::KIND_TICK, 0, 0, 129);                // one tick short of period
    push_item(mte_pkg::KIND_TICK, 0, 0, 130);                // settles
    push_item(mte_pkg::KIND_TOUCH, 10, 250, 32'hFFFF_FFF0);  // five-letter key
    push_item(mte_pkg::KIND_TOUCH, 10, 250, 32'hFFFF_FFF2);
    push_item(mte_pkg::KIND_TOUCH, 10, 250, 32'hFFFF_FFF4);
    push_item(mte_pkg::KIND_TOUCH, 10, 250, 32'hFFFF_FFF6);
    push_item(mte_pkg::KIND_TOUCH, 10, 250, 32'hFFFF_FFF8);
    push_item(mte_pkg::KIND_TOUCH, 10, 250, 32'hFFFF_FFFA);  // wraps to first letter
    push_item(mte_pkg::KIND_TICK, 0, 0, 32'h0000_0020);      // elapsed across wrap, short
    push_item(mte_pkg::KIND_TICK, 0, 0, 32'h0000_004A);      // elapsed across wrap, due
    push_item(mte_pkg::KIND_TOUCH, 120, 300, 32'h100);       // space key
    push_item(mte_pkg::KIND_TOUCH, 120, 300, 32'h101);
    push_item(mte_pkg::KIND_TOUCH, 239, 160, 32'h102);       // last column inside screen
    push_item(mte_pkg::KIND_TOUCH, 0, 319, 32'h103);         // delete
    push_item(mte_pkg::KIND_CLEAR, 4095, 4095, 32'hFFFF_FFFF);
    push_item(mte_pkg::KIND_TOUCH, 0, 300, 32'h104);         // delete on empty text
    push_item(mte_pkg::KIND_TOUCH, 239, 319, 32'h105);       // submit
    push_item(mte_pkg::KIND_TOUCH, 100, 159, 32'h106);       // above keypad
    push_item(mte_pkg::KIND_TOUCH, 100, 320, 32'h107);       // below keypad
    push_item(mte_pkg::KIND_TOUCH, 240, 200, 32'h108);       // right of screen
    push_item(KIND_UNUSED, 4095, 4095, 32'hFFFF_FFFF);
    push_item(mte_pkg::KIND_TOUCH, 4095, 4095, 32'h109);
    wait_drained();

    // Fill the text until it is full (63 characters), then refuse, delete, append, refuse
    for (int i = 0; i < 70; i++)
      push_item(mte_pkg::KIND_TOUCH, 80 + 80 * (i % 2) + 5, 170, 32'h200 + i);
    push_item(mte_pkg::KIND_TOUCH, 0, 300, 32'h300);
    push_item(mte_pkg::KIND_TOUCH, 5, 170, 32'h301);
    push_item(mte_pkg::KIND_TOUCH, 85, 170, 32'h302);
    push_item(mte_pkg::KIND_CLEAR, 0, 0, 32'h303);
    wait_drained();

    // Zero period and zero key size: one-pixel keys in the corner
    load_geometry(16'd0, 16'd0, 16'd0, 16'd0, 16'd4095, 16'd4095);
    queue_random_typing(100);
    wait_drained();

    // Largest sizes and period: a single reachable key
    load_geometry(16'hFFFF, 16'd4095, 16'd4095, 16'd0, 16'd4095, 16'd4095);
    queue_random_typing(50);
    wait_drained();

    set_idling(66, 33);
    // Keypad in a large area: cells past row 3 and column 2 reachable
    load_geometry(16'd200, 16'd100, 16'd50, 16'd100, 16'd4095, 16'd4095);
    queue_random_typing(150);
    wait_drained();

    // Inverted area: every touch falls outside; spare indexes ignored
    load_geometry(16'd1, 16'd1, 16'd1, 16'd4095, 16'd0, 16'd1);
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h0000);
    @(negedge clk);
    queue_random_typing(30);
    wait_drained();

    // Back to the reset geometry, no idling, with a long receiver hold
    set_idling(0, 0);
    load_geometry(mte_pkg::RST_CYCLE_PERIOD, 16'(mte_pkg::RST_KEY_WIDTH),
                  16'(mte_pkg::RST_KEY_HEIGHT), 16'(mte_pkg::RST_KEYPAD_TOP),
                  16'(mte_pkg::RST_KEYPAD_BOTTOM), 16'(mte_pkg::RST_SCREEN_WIDTH));
    queue_random_typing(150);
    repeat (60) @(negedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    hold_req = 1'b0;
    wait_drained();
    queue_random_typing(150);
    wait_drained();

    if (mismatches == 0 && keypad_results_q.size() == 0) begin
      $display("multitap_text_entry_tb: clean");
    end else begin
      $display("multitap_text_entry_tb: errors");
    end
    $finish;
  end

endmodule
